@@ src/pixel_hue_brightness_ghost_effect_assert.svh @@
// Assertion macros used by the checker file of the pixel effect block.
`ifndef PIXEL_HUE_BRIGHTNESS_GHOST_EFFECT_ASSERT_SVH
`define PIXEL_HUE_BRIGHTNESS_GHOST_EFFECT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define PHBG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PHBG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/phbg_pkg.sv @@
// Types, constants, tables and helper functions of the pixel effect pipeline.
`default_nettype none

package phbg_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_HUE_ENABLE  = 2'd0,
    CFG_HUE_SHIFT   = 2'd1,
    CFG_BRIGHTNESS  = 2'd2,
    CFG_GHOST_ALPHA = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] MIN_V = 16'd3604;
  localparam logic [15:0] MIN_S = 16'd5898;
  localparam logic [15:0] FULL  = 16'hFFFF;

  // Pipeline stage positions.
  localparam int ST_PRE      = 0;
  localparam int ST_NUM      = 1;
  localparam int ST_DIV0     = 2;
  localparam int DIV_STAGES  = 8;
  localparam int ST_HSV      = ST_DIV0 + DIV_STAGES;
  localparam int ST_H6       = ST_HSV + 1;
  localparam int ST_MUL1     = ST_H6 + 1;
  localparam int ST_MUL2     = ST_MUL1 + 1;
  localparam int ST_RED      = ST_MUL2 + 1;
  localparam int ST_CH       = ST_RED + 1;
  localparam int ST_BRI      = ST_CH + 1;
  localparam int ST_OUT      = ST_BRI + 1;
  localparam int NST         = ST_OUT + 1;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_t;

  // State of one restoring divider: partial remainder, the dividend bits
  // still to come, and the quotient built so far.
  typedef struct packed {
    logic [10:0] rem;
    logic [15:0] lo;
    logic [15:0] q;
  } div_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [7:0]  mx;
    logic [7:0]  mn;
    max_sel_t    sel;
    logic [7:0]  d;
    div_t        sd;
    div_t        hd;
    logic [10:0] hdv;
    logic [15:0] v;
    logic [15:0] s;
    logic [15:0] h;
    logic [2:0]  sector;
    logic [15:0] f;
    logic [15:0] fs;
    logic [15:0] gs;
    logic [31:0] pm;
    logic [31:0] qm;
    logic [31:0] tm;
    logic [15:0] p;
    logic [15:0] q;
    logic [15:0] t;
    logic [15:0] am;
  } pl_t;

  typedef logic [15:0]        rot_tbl_t [256];
  typedef logic signed [9:0]  bri_tbl_t [256];

  function automatic rot_tbl_t build_rot();
    rot_tbl_t tb;
    for (int i = 0; i < 256; i++) begin
      tb[i] = 16'((((i % 200) * 65536) + 100) / 200);
    end
    return tb;
  endfunction

  function automatic bri_tbl_t build_bri();
    bri_tbl_t tb;
    int sv;
    for (int i = 0; i < 256; i++) begin
      sv = (i >= 128) ? i - 256 : i;
      tb[i] = 10'((sv * 255) / 100);
    end
    return tb;
  endfunction

  // Hue increment per shift code, and brightness offset per brightness code.
  localparam rot_tbl_t ROT_TBL = build_rot();
  localparam bri_tbl_t BRI_TBL = build_bri();

  // One quotient bit of a restoring division.
  function automatic div_t div_step(input div_t x, input logic [10:0] dv);
    div_t        y;
    logic [11:0] tr;
    tr = {x.rem, x.lo[15]};
    y.lo = {x.lo[14:0], 1'b0};
    if (tr >= {1'b0, dv}) begin
      y.rem = 11'(tr - {1'b0, dv});
      y.q   = {x.q[14:0], 1'b1};
    end else begin
      y.rem = tr[10:0];
      y.q   = {x.q[14:0], 1'b0};
    end
    return y;
  endfunction

  // (x + 32767) / 65535 through the reciprocal identity, exact below 2^32.
  function automatic logic [15:0] div_full(input logic [31:0] x);
    logic [32:0] y;
    logic [32:0] z;
    y = 33'(x) + 33'd32767;
    z = y + 33'(y[32:16]) + 33'd1;
    return z[31:16];
  endfunction

  // (x + 128) / 257 as a multiply by 255 and a shift, exact here.
  function automatic logic [7:0] frac_to_ch(input logic [15:0] x);
    logic [16:0] y;
    logic [25:0] z;
    y = 17'(x) + 17'd128;
    z = 26'({y, 8'b0}) - 26'(y) + 26'd255;
    return z[23:16];
  endfunction

endpackage

`default_nettype wire

@@ src/pixel_hue_brightness_ghost_effect.sv @@
// Top level of the pixel hue, brightness and ghost effect pipeline.
// One pixel per clock goes in and one shaded pixel comes out while m_tready
// is high; the two 16-bit restoring dividers of the RGB to HSV step retire
// two quotient bits in each of eight stages. Each stage holds only when the
// stage after it is full and cannot move, so bubbles close up and a waiting
// result stops new requests only once every stage is full. Input tdata is
// alpha, blue, green, red from the top byte down; the result carries the
// same layout in m_tdata and the visible flag in m_tuser. With hue enabled
// the colour is rotated in HSV with a floor on value and saturation;
// brightness is then added and clamped, and alpha is scaled by ghost alpha.
// Configuration must only change while the pipeline is empty.
`default_nettype none

module pixel_hue_brightness_ghost_effect
  import phbg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic             m_tuser,   // visible[0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic       hue_enable;
  logic [7:0] hue_shift;
  logic [7:0] brightness;
  logic [7:0] ghost_alpha;

  pl_t  st  [NST];
  pl_t  nx  [NST];
  logic vld [NST];
  logic adv [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_enable  <= 1'b0;
      hue_shift   <= 8'd0;
      brightness  <= 8'd0;
      ghost_alpha <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HUE_ENABLE:  hue_enable  <= cfg_data[0];
        CFG_HUE_SHIFT:   hue_shift   <= cfg_data;
        CFG_BRIGHTNESS:  brightness  <= cfg_data;
        CFG_GHOST_ALPHA: ghost_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[NST-1] = !vld[NST-1] || m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_comb begin
    logic [7:0]         r0, g0, b0, mx0, mn0, dd;
    logic signed [12:0] num;
    logic [23:0]        ns;
    logic [26:0]        nh;
    logic [15:0]        vv, ss, hh;
    logic [18:0]        h6;
    logic [31:0]        fsp;
    logic [33:0]        gsp;
    logic [15:0]        ro, go, bo;
    logic signed [10:0] sr, sg, sb;
    logic signed [9:0]  add;
    logic [16:0]        aq;

    r0 = s_tdata[7:0];
    g0 = s_tdata[15:8];
    b0 = s_tdata[23:16];
    mx0 = (r0 > g0) ? r0 : g0;
    if (b0 > mx0) mx0 = b0;
    mn0 = (r0 < g0) ? r0 : g0;
    if (b0 < mn0) mn0 = b0;

    nx[ST_PRE] = '0;
    nx[ST_PRE].r  = r0;
    nx[ST_PRE].g  = g0;
    nx[ST_PRE].b  = b0;
    nx[ST_PRE].a  = s_tdata[31:24];
    nx[ST_PRE].mx = mx0;
    nx[ST_PRE].mn = mn0;
    if (mx0 == r0) nx[ST_PRE].sel = MAX_RED;
    else if (mx0 == g0) nx[ST_PRE].sel = MAX_GREEN;
    else nx[ST_PRE].sel = MAX_BLUE;

    for (int k = 1; k < NST; k++) begin
      nx[k] = st[k-1];
    end

    // Hue numerator and both dividends.
    dd = st[ST_NUM-1].mx - st[ST_NUM-1].mn;
    case (st[ST_NUM-1].sel)
      MAX_RED:   num = $signed({5'b0, st[ST_NUM-1].g}) - $signed({5'b0, st[ST_NUM-1].b});
      MAX_GREEN: num = $signed({4'b0, dd, 1'b0}) + $signed({5'b0, st[ST_NUM-1].b})
                       - $signed({5'b0, st[ST_NUM-1].r});
      default:   num = $signed({3'b0, dd, 2'b0}) + $signed({5'b0, st[ST_NUM-1].r})
                       - $signed({5'b0, st[ST_NUM-1].g});
    endcase
    if (num < 0) num = num + $signed({3'b0, dd, 2'b0}) + $signed({4'b0, dd, 1'b0});
    ns = {dd, 16'b0} - 24'(dd) + 24'(st[ST_NUM-1].mx[7:1]);
    nh = {num[10:0], 16'b0} + 27'(dd) + 27'({dd, 1'b0});
    nx[ST_NUM].d      = dd;
    nx[ST_NUM].sd.rem = {3'b0, ns[23:16]};
    nx[ST_NUM].sd.lo  = ns[15:0];
    nx[ST_NUM].sd.q   = '0;
    nx[ST_NUM].hd.rem = nh[26:16];
    nx[ST_NUM].hd.lo  = nh[15:0];
    nx[ST_NUM].hd.q   = '0;
    nx[ST_NUM].hdv    = 11'({dd, 2'b0}) + 11'({dd, 1'b0});

    for (int k = ST_DIV0; k < ST_DIV0 + DIV_STAGES; k++) begin
      nx[k].sd = div_step(div_step(st[k-1].sd, {3'b0, st[k-1].mx}), {3'b0, st[k-1].mx});
      nx[k].hd = div_step(div_step(st[k-1].hd, st[k-1].hdv), st[k-1].hdv);
    end

    // HSV with the value and saturation floors, then the rotation.
    vv = {st[ST_HSV-1].mx, st[ST_HSV-1].mx};
    ss = (st[ST_HSV-1].mx == 8'd0) ? 16'd0 : st[ST_HSV-1].sd.q;
    hh = (st[ST_HSV-1].d == 8'd0) ? 16'd0 : st[ST_HSV-1].hd.q;
    if (vv < MIN_V) begin
      hh = '0;
      ss = FULL;
      vv = MIN_V;
    end else if (ss < MIN_S) begin
      hh = '0;
      ss = MIN_S;
    end
    nx[ST_HSV].v = vv;
    nx[ST_HSV].s = ss;
    nx[ST_HSV].h = hh + ROT_TBL[hue_shift];

    h6 = 19'({st[ST_H6-1].h, 2'b0}) + 19'({st[ST_H6-1].h, 1'b0});
    nx[ST_H6].sector = h6[18:16];
    nx[ST_H6].f      = h6[15:0];

    fsp = 32'(st[ST_MUL1-1].f) * 32'(st[ST_MUL1-1].s);
    gsp = 34'(17'h10000 - 17'(st[ST_MUL1-1].f)) * 34'(st[ST_MUL1-1].s) + 34'd32768;
    nx[ST_MUL1].fs = 16'((33'(fsp) + 33'd32768) >> 16);
    nx[ST_MUL1].gs = gsp[31:16];
    nx[ST_MUL1].pm = 32'(st[ST_MUL1-1].v) * 32'(FULL - st[ST_MUL1-1].s);

    nx[ST_MUL2].qm = 32'(st[ST_MUL2-1].v) * 32'(FULL - st[ST_MUL2-1].fs);
    nx[ST_MUL2].tm = 32'(st[ST_MUL2-1].v) * 32'(FULL - st[ST_MUL2-1].gs);
    nx[ST_MUL2].p  = div_full(st[ST_MUL2-1].pm);

    nx[ST_RED].q = div_full(st[ST_RED-1].qm);
    nx[ST_RED].t = div_full(st[ST_RED-1].tm);

    case (st[ST_CH-1].sector)
      3'd0:    begin ro = st[ST_CH-1].v; go = st[ST_CH-1].t; bo = st[ST_CH-1].p; end
      3'd1:    begin ro = st[ST_CH-1].q; go = st[ST_CH-1].v; bo = st[ST_CH-1].p; end
      3'd2:    begin ro = st[ST_CH-1].p; go = st[ST_CH-1].v; bo = st[ST_CH-1].t; end
      3'd3:    begin ro = st[ST_CH-1].p; go = st[ST_CH-1].q; bo = st[ST_CH-1].v; end
      3'd4:    begin ro = st[ST_CH-1].t; go = st[ST_CH-1].p; bo = st[ST_CH-1].v; end
      default: begin ro = st[ST_CH-1].v; go = st[ST_CH-1].p; bo = st[ST_CH-1].q; end
    endcase
    if (hue_enable) begin
      nx[ST_CH].r = frac_to_ch(ro);
      nx[ST_CH].g = frac_to_ch(go);
      nx[ST_CH].b = frac_to_ch(bo);
    end

    add = BRI_TBL[brightness];
    sr = $signed({3'b0, st[ST_BRI-1].r}) + 11'(add);
    sg = $signed({3'b0, st[ST_BRI-1].g}) + 11'(add);
    sb = $signed({3'b0, st[ST_BRI-1].b}) + 11'(add);
    nx[ST_BRI].r  = (sr < 0) ? 8'd0 : ((sr > 11'sd255) ? 8'd255 : sr[7:0]);
    nx[ST_BRI].g  = (sg < 0) ? 8'd0 : ((sg > 11'sd255) ? 8'd255 : sg[7:0]);
    nx[ST_BRI].b  = (sb < 0) ? 8'd0 : ((sb > 11'sd255) ? 8'd255 : sb[7:0]);
    nx[ST_BRI].am = 16'(st[ST_BRI-1].a) * 16'(ghost_alpha);

    // Division of the alpha product by 255, then the invisible case.
    aq = 17'(st[ST_OUT-1].am) + 17'(st[ST_OUT-1].am[15:8]) + 17'd1;
    nx[ST_OUT].a = aq[15:8];
    if (aq[15:8] == 8'd0) begin
      nx[ST_OUT].r = '0;
      nx[ST_OUT].g = '0;
      nx[ST_OUT].b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vld[k] <= 1'b0;
    end else begin
      if (adv[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (adv[k]) st[k] <= nx[k];
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {st[NST-1].a, st[NST-1].b, st[NST-1].g, st[NST-1].r};
  assign m_tuser  = (st[NST-1].a != 8'd0);

endmodule

`default_nettype wire

@@ src/phbg_checker.sv @@
// Port-level checker of the pixel effect block and its bind.
`default_nettype none

`include "pixel_hue_brightness_ghost_effect_assert.svh"

module phbg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser
);

  // An empty output stage means the whole pipeline can move.
  `PHBG_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready,
    "request refused with empty output")
  `PHBG_ASSERT(a_invisible_zero, (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0),
    "invisible pixel not zero")
  `PHBG_ASSERT(a_visible_alpha, (m_tvalid && m_tuser) |-> (m_tdata[31:24] != 8'd0),
    "visible with zero alpha")
  `PHBG_ASSERT(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
    "stalled result changed")
  `PHBG_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result after reset")

endmodule

bind pixel_hue_brightness_ghost_effect phbg_checker u_phbg_checker (.*);

`default_nettype wire
